// ===== hdl/npds_pkg.sv =====
`default_nettype none

package npds_pkg;

  localparam int NUM_CH          = 3;
  localparam int LEVEL_W         = 32;
  localparam int GAIN_W          = 16;
  localparam int LEVELS_W        = NUM_CH * LEVEL_W;
  localparam int MAX_COLUMNS_DEF = 64;
  localparam int MAX_ROWS        = 1024;
  localparam int ROW_W           = 10;
  localparam int GRID_COLS_W     = 7;
  localparam int GRID_ROWS_W     = 11;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 32;
  localparam int TAPS            = 9;

  // Signed stencil weights with 16 fraction bits (diagonal Q0.16, center Q3.16): diagonal 0.70710678, center 6.82842712
  localparam logic signed [16:0] K_DIAG   = 17'sd46341;
  localparam logic signed [19:0] K_CENTER = 20'sd447508;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_FIRST     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_SECOND    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_THIRD     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUTSIDE_FIRST  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUTSIDE_SECOND = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OUTSIDE_THIRD  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLUMNS   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS      = 3'd7;

  typedef logic [NUM_CH-1:0][LEVEL_W-1:0] levels_t;

  typedef struct packed {
    levels_t up;
    levels_t mid;
    levels_t low;
  } column_t;

  // element i is tap w[i]: 0..2 two columns back, 3..5 one back, 6..8 newest
  typedef logic [TAPS-1:0][LEVEL_W-1:0] chan_taps_t;
  typedef chan_taps_t [NUM_CH-1:0] all_taps_t;

  // per-stage load enables of the arithmetic pipeline
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } adv_t;

endpackage

`default_nettype wire

// ===== hdl/npds_ram.sv =====
`default_nettype none

module npds_ram #(
  parameter int WIDTH = 192,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/npds_raster.sv =====
`default_nettype none

module npds_raster
  import npds_pkg::*;
#(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   fire,
  input  wire levels_t                in_levels,
  input  wire logic                   border,
  input  wire levels_t                outside,
  input  wire logic [GRID_COLS_W-1:0] grid_columns,
  input  wire logic [GRID_ROWS_W-1:0] grid_rows,
  output all_taps_t                   taps,
  output logic                        produce,
  output logic                        last_site
);

  localparam int CW  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int CCW = (CW + 1 > GRID_COLS_W) ? CW + 1 : GRID_COLS_W;

  logic [CW-1:0]          col;
  logic [CW-1:0]          col_next;
  logic [ROW_W-1:0]       row;
  logic [CCW-1:0]         cols_eff;
  logic [CCW-1:0]         gc_ext;
  logic [CCW-1:0]         col_inc;
  logic                   col_wrap;
  logic [GRID_ROWS_W-1:0] rows_eff;
  logic [GRID_ROWS_W-1:0] row_inc;
  logic                   row_wrap;
  levels_t                site;
  levels_t                up_rd;
  levels_t                mid_rd;
  logic [2*LEVELS_W-1:0]  ram_rdata;
  logic [CW-1:0]          ram_raddr;
  column_t                win_a;
  column_t                win_b;

  // clamp the grid size to what the stores hold
  always_comb begin
    gc_ext = CCW'(grid_columns);
    if (gc_ext < CCW'(3)) begin
      cols_eff = CCW'(3);
    end else if (gc_ext > CCW'(MAX_COLUMNS)) begin
      cols_eff = CCW'(MAX_COLUMNS);
    end else begin
      cols_eff = gc_ext;
    end
    if (grid_rows < GRID_ROWS_W'(3)) begin
      rows_eff = GRID_ROWS_W'(3);
    end else if (grid_rows > GRID_ROWS_W'(MAX_ROWS)) begin
      rows_eff = GRID_ROWS_W'(MAX_ROWS);
    end else begin
      rows_eff = grid_rows;
    end
  end

  assign col_inc  = CCW'(col) + CCW'(1);
  assign col_wrap = (col_inc >= cols_eff);
  assign col_next = col_wrap ? '0 : col_inc[CW-1:0];
  assign row_inc  = GRID_ROWS_W'(row) + GRID_ROWS_W'(1);
  assign row_wrap = (row_inc >= rows_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (fire) begin
      col <= col_next;
      if (col_wrap) begin
        row <= row_wrap ? '0 : row_inc[ROW_W-1:0];
      end
    end
  end

  assign site = border ? outside : in_levels;

  // read one column ahead so the store data is ready when the next site lands
  assign ram_raddr = fire ? col_next : col;
  assign up_rd     = ram_rdata[2*LEVELS_W-1:LEVELS_W];
  assign mid_rd    = ram_rdata[LEVELS_W-1:0];

  // upper half holds the upper row, lower half the middle row
  npds_ram #(
    .WIDTH(2 * LEVELS_W),
    .DEPTH(MAX_COLUMNS)
  ) u_rows (
    .clk  (clk),
    .we   (fire),
    .waddr(col),
    .wdata({mid_rd, site}),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (fire) begin
      win_a <= win_b;
      win_b <= '{up: up_rd, mid: mid_rd, low: site};
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      taps[k][0] = win_a.up[k];
      taps[k][1] = win_a.mid[k];
      taps[k][2] = win_a.low[k];
      taps[k][3] = win_b.up[k];
      taps[k][4] = win_b.mid[k];
      taps[k][5] = win_b.low[k];
      taps[k][6] = up_rd[k];
      taps[k][7] = mid_rd[k];
      taps[k][8] = site[k];
    end
  end

  assign produce   = (row >= ROW_W'(2)) && (col >= CW'(2));
  assign last_site = (GRID_ROWS_W'(row) == rows_eff - GRID_ROWS_W'(1))
                  && (CCW'(col) == cols_eff - CCW'(1));

endmodule

`default_nettype wire

// ===== hdl/npds_chan.sv =====
`default_nettype none

module npds_chan
  import npds_pkg::*;
(
  input  wire logic              clk,
  input  wire chan_taps_t        taps,
  input  wire logic [GAIN_W-1:0] gain,
  input  wire adv_t              adv,
  output logic [LEVEL_W-1:0]     level
);

  localparam int SUMW = LEVEL_W + 2;
  localparam int DPW  = SUMW + 17;
  localparam int CPW  = LEVEL_W + 20;
  localparam int IW   = 54;
  localparam int RW   = IW - 16;
  localparam int PRW  = RW + GAIN_W + 1;
  localparam int SW   = PRW - 16 + 1;

  logic signed [SUMW-1:0]    orth_sum;
  logic signed [SUMW-1:0]    diag_sum;
  logic signed [LEVEL_W-1:0] center;
  logic signed [DPW-1:0]     pdiag_next;
  logic signed [CPW-1:0]     pcent_next;

  logic signed [SUMW-1:0]    orth_q;
  logic signed [DPW-1:0]     pdiag_q;
  logic signed [CPW-1:0]     pcent_q;
  logic signed [LEVEL_W-1:0] center1;

  logic signed [IW-1:0]      inner;
  logic signed [IW-1:0]      inner_rnd;
  logic signed [RW-1:0]      rnd_q;
  logic signed [LEVEL_W-1:0] center2;

  logic signed [PRW-1:0]     prod_next;
  logic signed [PRW-1:0]     prod_q;
  logic signed [LEVEL_W-1:0] center3;

  logic signed [PRW-1:0]     prod_rnd;
  logic signed [SW-1:0]      total;
  logic [LEVEL_W-1:0]        level_next;

  // stage 1: neighbor sums and the two constant products
  always_comb begin
    orth_sum = SUMW'($signed(taps[1])) + SUMW'($signed(taps[3]))
             + SUMW'($signed(taps[5])) + SUMW'($signed(taps[7]));
    diag_sum = SUMW'($signed(taps[0])) + SUMW'($signed(taps[2]))
             + SUMW'($signed(taps[6])) + SUMW'($signed(taps[8]));
    center     = $signed(taps[4]);
    pdiag_next = DPW'(diag_sum) * DPW'(K_DIAG);
    pcent_next = CPW'(center) * CPW'(K_CENTER);
  end

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      orth_q  <= orth_sum;
      pdiag_q <= pdiag_next;
      pcent_q <= pcent_next;
      center1 <= center;
    end
  end

  // stage 2: bracket in Q.32, round to Q16.16
  always_comb begin
    inner     = (IW'(orth_q) <<< 16) + IW'(pdiag_q) - IW'(pcent_q);
    inner_rnd = (inner + IW'(32768)) >>> 16;
  end

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      rnd_q   <= inner_rnd[RW-1:0];
      center2 <= center1;
    end
  end

  // stage 3: apply the gain
  assign prod_next = PRW'(rnd_q) * PRW'($signed({1'b0, gain}));

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      prod_q  <= prod_next;
      center3 <= center2;
    end
  end

  // stage 4: round, add the center back, saturate
  always_comb begin
    prod_rnd = (prod_q + PRW'(32768)) >>> 16;
    total    = SW'(prod_rnd) + SW'(center3);
    if (total > SW'(64'sh7FFF_FFFF)) begin
      level_next = {1'b0, {(LEVEL_W-1){1'b1}}};
    end else if (total < -SW'(64'sh8000_0000)) begin
      level_next = {1'b1, {(LEVEL_W-1){1'b0}}};
    end else begin
      level_next = total[LEVEL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s4) begin
      level <= level_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/nine_point_diffusion_stencil_top.sv =====
// Nine-point diffusion stencil, one explicit diffusion round per frame.
// Input channel (in_valid/in_ready): one grid site per transaction in raster
// order, three Q16.16 levels plus border_site, which swaps in the outside
// levels. Output channel (out_valid/out_ready): one transaction for each site
// off the outer ring, started when the site below-right of it is taken;
// frame_end marks the last one of the round.
// Configuration channel (cfg_valid/cfg_ready, always ready): cfg_index picks
// the gain, outside level or grid size register; write only while idle.
// Throughput: one site per cycle while the receiver keeps up. Each result
// passes through the four-stage arithmetic pipeline (two multiplies in the
// first stage and one in the third, each stage ending in a register).
// Both row stores live in one RAM read one column ahead of the raster
// position, so a new site is taken every cycle unless all stages are full.
// When the receiver stalls, results back up through the pipeline stages and
// in_ready drops only once all four are full.
// Reset clears the raster position, the pipeline and the registers (gains
// and outside levels to zero, grid to 64 by 64). The row stores are not
// cleared: the first two rows of a round only fill them.
`default_nettype none

module nine_point_diffusion_stencil_top
  import npds_pkg::*;
#(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [LEVEL_W-1:0]    level_first,
  input  wire logic [LEVEL_W-1:0]    level_second,
  input  wire logic [LEVEL_W-1:0]    level_third,
  input  wire logic                  border_site,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [LEVEL_W-1:0]         new_level_first,
  output logic [LEVEL_W-1:0]         new_level_second,
  output logic [LEVEL_W-1:0]         new_level_third,
  output logic                       frame_end,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic [NUM_CH-1:0][GAIN_W-1:0] gain;
  levels_t                       outside;
  logic [GRID_COLS_W-1:0]        grid_columns;
  logic [GRID_ROWS_W-1:0]        grid_rows;

  logic      in_fire;
  levels_t   in_levels;
  all_taps_t taps;
  logic      produce;
  logic      last_site;

  logic      v1, v2, v3;
  logic      f1, f2, f3;
  logic      ready1, ready2, ready3, ready4;
  adv_t      adv;
  levels_t   result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain         <= '0;
      outside      <= '0;
      grid_columns <= GRID_COLS_W'(64);
      grid_rows    <= GRID_ROWS_W'(64);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_GAIN_FIRST:     gain[0]      <= cfg_data[GAIN_W-1:0];
        REG_GAIN_SECOND:    gain[1]      <= cfg_data[GAIN_W-1:0];
        REG_GAIN_THIRD:     gain[2]      <= cfg_data[GAIN_W-1:0];
        REG_OUTSIDE_FIRST:  outside[0]   <= cfg_data[LEVEL_W-1:0];
        REG_OUTSIDE_SECOND: outside[1]   <= cfg_data[LEVEL_W-1:0];
        REG_OUTSIDE_THIRD:  outside[2]   <= cfg_data[LEVEL_W-1:0];
        REG_GRID_COLUMNS:   grid_columns <= cfg_data[GRID_COLS_W-1:0];
        REG_GRID_ROWS:      grid_rows    <= cfg_data[GRID_ROWS_W-1:0];
      endcase
    end
  end

  // each stage loads when it is empty or its successor moves on
  assign ready4   = !out_valid || out_ready;
  assign ready3   = !v3 || ready4;
  assign ready2   = !v2 || ready3;
  assign ready1   = !v1 || ready2;
  assign in_ready = ready1;
  assign in_fire  = in_valid && in_ready;
  assign adv      = '{s1: ready1, s2: ready2, s3: ready3, s4: ready4};

  assign in_levels = {level_third, level_second, level_first};

  npds_raster #(
    .MAX_COLUMNS(MAX_COLUMNS)
  ) u_raster (
    .clk         (clk),
    .rst         (rst),
    .fire        (in_fire),
    .in_levels   (in_levels),
    .border      (border_site),
    .outside     (outside),
    .grid_columns(grid_columns),
    .grid_rows   (grid_rows),
    .taps        (taps),
    .produce     (produce),
    .last_site   (last_site)
  );

  for (genvar k = 0; k < NUM_CH; k++) begin : g_chan
    npds_chan u_chan (
      .clk  (clk),
      .taps (taps[k]),
      .gain (gain[k]),
      .adv  (adv),
      .level(result[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ready1) v1        <= in_fire && produce;
      if (ready2) v2        <= v1;
      if (ready3) v3        <= v2;
      if (ready4) out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1) f1        <= last_site;
    if (ready2) f2        <= f1;
    if (ready3) f3        <= f2;
    if (ready4) frame_end <= f3;
  end

  assign new_level_first  = result[0];
  assign new_level_second = result[1];
  assign new_level_third  = result[2];

  // input side backs up only when every stage holds a result
  a_full_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (v1 && v2 && v3 && out_valid))
    else $error("input blocked with an empty pipeline stage");

  // an interior site must start a result in the first stage
  a_interior_enters: assert property (@(posedge clk) disable iff (rst)
    (in_fire && produce) |=> v1)
    else $error("interior site lost on entry");

  // no result enters without an accepted interior site
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    (ready1 && !(in_fire && produce)) |=> !v1)
    else $error("result entered without an interior site");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
`default_nettype none

module tb;
  import npds_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_COLS     = MAX_COLUMNS_DEF;
  localparam int HOLD_AT      = 30;
  localparam int HOLD_CYCLES  = 80;
  localparam int SETTLE       = 8;
  localparam int TAIL_CYCLES  = 20;
  localparam int STALL_LIMIT  = 1000;
  localparam int RANDOM_SITES = 380;
  localparam int CALM_FROM    = 300;

  localparam logic [LEVEL_W-1:0] LVL_MAX = 32'h7FFF_FFFF;
  localparam logic [LEVEL_W-1:0] LVL_MIN = 32'h8000_0000;

  typedef struct {
    levels_t lv;
    logic    border;
  } site_t;

  typedef struct {
    levels_t lv;
    logic    last;
  } diffused_t;

  logic clk;
  logic rst = 1'b1;

  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [LEVEL_W-1:0]    level_first = '0;
  logic [LEVEL_W-1:0]    level_second = '0;
  logic [LEVEL_W-1:0]    level_third = '0;
  logic                  border_site = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [LEVEL_W-1:0]    new_level_first;
  logic [LEVEL_W-1:0]    new_level_second;
  logic [LEVEL_W-1:0]    new_level_third;
  logic                  frame_end;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  nine_point_diffusion_stencil_top u_top (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .level_first      (level_first),
    .level_second     (level_second),
    .level_third      (level_third),
    .border_site      (border_site),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .new_level_first  (new_level_first),
    .new_level_second (new_level_second),
    .new_level_third  (new_level_third),
    .frame_end        (frame_end),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // register shadows, as the block holds them
  logic [GAIN_W-1:0]      gain_sh [NUM_CH];
  levels_t                outside_sh = '0;
  logic [GRID_COLS_W-1:0] cols_sh = 7'd64;
  logic [GRID_ROWS_W-1:0] rows_sh = 11'd64;

  // stencil state of the predictor
  levels_t upper_store [MAX_COLS];
  levels_t middle_store [MAX_COLS];
  levels_t window_cols [6];
  int      col_pos = 0;
  int      row_pos = 0;

  site_t     site_queue [$];
  diffused_t due_levels [$];

  bit idle_on = 1'b1;
  int mismatch_count = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    for (int ch = 0; ch < NUM_CH; ch++) gain_sh[ch] = '0;
  end

  function automatic int grid_extent(input int value, input int hi);
    if (value < 3) return 3;
    if (value > hi) return hi;
    return value;
  endfunction

  function automatic longint sx(input logic [LEVEL_W-1:0] v);
    return longint'(signed'(v));
  endfunction

  // one site enters the raster: update the stores and queue the diffused
  // levels of the site above-left once its window is complete
  task automatic take_site(input levels_t raw, input logic border);
    levels_t   site;
    levels_t   taps [9];
    int        cols;
    int        rows;
    longint    orth;
    longint    diag;
    longint    ctr;
    longint    inner;
    longint    acc;
    diffused_t res;
    cols = grid_extent(int'(cols_sh), MAX_COLS);
    rows = grid_extent(int'(rows_sh), MAX_ROWS);
    for (int ch = 0; ch < NUM_CH; ch++) site[ch] = border ? outside_sh[ch] : raw[ch];
    for (int k = 0; k < 6; k++) taps[k] = window_cols[k];
    taps[6] = upper_store[col_pos];
    taps[7] = middle_store[col_pos];
    taps[8] = site;
    upper_store[col_pos] = middle_store[col_pos];
    middle_store[col_pos] = site;
    if (row_pos >= 2 && col_pos >= 2) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        orth  = sx(taps[1][ch]) + sx(taps[3][ch]) + sx(taps[5][ch]) + sx(taps[7][ch]);
        diag  = sx(taps[0][ch]) + sx(taps[2][ch]) + sx(taps[6][ch]) + sx(taps[8][ch]);
        ctr   = sx(taps[4][ch]);
        inner = orth * 65536 + diag * longint'(K_DIAG) - ctr * longint'(K_CENTER);
        acc   = (inner + 32768) >>> 16;
        acc   = ((acc * longint'(gain_sh[ch]) + 32768) >>> 16) + ctr;
        if (acc > 64'sh7FFF_FFFF) acc = 64'sh7FFF_FFFF;
        if (acc < -64'sh8000_0000) acc = -64'sh8000_0000;
        res.lv[ch] = acc[LEVEL_W-1:0];
      end
      res.last = (row_pos == rows - 1) && (col_pos == cols - 1);
      due_levels.push_back(res);
    end
    for (int k = 0; k < 6; k++) window_cols[k] = taps[k + 3];
    col_pos++;
    if (col_pos >= cols) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= rows) row_pos = 0;
    end
  endtask

  // driver: offer sites from the queue, with random gaps
  site_t cur_site;
  int    send_gap = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) take_site(cur_site.lv, cur_site.border);
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (site_queue.size() != 0) begin
          cur_site = site_queue.pop_front();
          level_first  <= cur_site.lv[0];
          level_second <= cur_site.lv[1];
          level_third  <= cur_site.lv[2];
          border_site  <= cur_site.border;
          in_valid     <= 1'b1;
          if (idle_on && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 4);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each result transaction, stall at random, hold off once
  int results_seen = 0;
  int hold_left = 0;
  int stall_left = 0;

  always @(posedge clk) begin
    levels_t   got;
    diffused_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = {new_level_third, new_level_second, new_level_first};
        if (due_levels.size() == 0) begin
          $display("%0t: result with none expected: %h %h %h frame_end %b", $time,
                   got[0], got[1], got[2], frame_end);
          mismatch_count++;
        end else begin
          want = due_levels.pop_front();
          for (int ch = 0; ch < NUM_CH; ch++) begin
            if (got[ch] !== want.lv[ch]) begin
              $display("%0t: channel %0d level: expected %h, got %h", $time, ch,
                       want.lv[ch], got[ch]);
              mismatch_count++;
            end
          end
          if (frame_end !== want.last) begin
            $display("%0t: frame_end: expected %b, got %b", $time, want.last, frame_end);
            mismatch_count++;
          end
        end
        results_seen++;
        if (results_seen == HOLD_AT) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 3);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog: stop when no transaction of any kind moves for too long
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // call right after a rising edge
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_GAIN_FIRST:     gain_sh[0] = data[GAIN_W-1:0];
      REG_GAIN_SECOND:    gain_sh[1] = data[GAIN_W-1:0];
      REG_GAIN_THIRD:     gain_sh[2] = data[GAIN_W-1:0];
      REG_OUTSIDE_FIRST:  outside_sh[0] = data;
      REG_OUTSIDE_SECOND: outside_sh[1] = data;
      REG_OUTSIDE_THIRD:  outside_sh[2] = data;
      REG_GRID_COLUMNS:   cols_sh = data[GRID_COLS_W-1:0];
      REG_GRID_ROWS:      rows_sh = data[GRID_ROWS_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_levels(input logic [GAIN_W-1:0] g0, g1, g2,
                              input logic [LEVEL_W-1:0] o0, o1, o2);
    write_reg(REG_GAIN_FIRST, 32'(g0));
    write_reg(REG_GAIN_SECOND, 32'(g1));
    write_reg(REG_GAIN_THIRD, 32'(g2));
    write_reg(REG_OUTSIDE_FIRST, o0);
    write_reg(REG_OUTSIDE_SECOND, o1);
    write_reg(REG_OUTSIDE_THIRD, o2);
  endtask

  // wait until every site is taken and every result is in, then let the
  // pipeline settle
  task automatic drain();
    while (site_queue.size() != 0 || in_valid || due_levels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [LEVEL_W-1:0] pick_level();
    case ($urandom_range(0, 7))
      0:       return LVL_MAX;
      1:       return LVL_MIN;
      2:       return '0;
      3, 4:    return $urandom();
      default: return 32'($urandom_range(0, 32'h00FF_FFFF)) - 32'h0080_0000;
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return GAIN_W'($urandom());
    endcase
  endfunction

  // queue one whole round; border_mode 0 none, 1 outer ring, 2 scattered
  task automatic run_round(input int cols_w, input int rows_w, input int border_mode,
                           input bit pause_mid);
    int      cols;
    int      rows;
    site_t   s;
    logic    ring;
    write_reg(REG_GRID_COLUMNS, 32'(cols_w));
    write_reg(REG_GRID_ROWS, 32'(rows_w));
    cols = grid_extent(int'(cols_sh), MAX_COLS);
    rows = grid_extent(int'(rows_sh), MAX_ROWS);
    for (int r = 0; r < rows; r++) begin
      // hold the sender until everything so far has come back
      if (pause_mid && r == rows / 2) drain();
      for (int c = 0; c < cols; c++) begin
        ring = (r == 0) || (r == rows - 1) || (c == 0) || (c == cols - 1);
        for (int ch = 0; ch < NUM_CH; ch++) s.lv[ch] = pick_level();
        case (border_mode)
          1:       s.border = ring;
          2:       s.border = ($urandom_range(0, 3) == 0);
          default: s.border = 1'b0;
        endcase
        site_queue.push_back(s);
      end
    end
    drain();
  endtask

  initial begin
    site_t s;
    int    random_sites;
    int    cols_w;
    int    rows_w;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: out-of-range sizes clamp to a 3x3 grid, full gains
    write_levels('1, '1, '1, LVL_MAX, LVL_MIN, '0);
    write_reg(REG_GRID_COLUMNS, 32'd0);
    write_reg(REG_GRID_ROWS, 32'd2);
    // full-scale ring around the opposite extreme: drives saturation
    for (int k = 0; k < 9; k++) begin
      s.lv = (k == 4) ? {LVL_MIN, LVL_MIN, LVL_MIN} : {LVL_MAX, LVL_MAX, LVL_MAX};
      s.border = 1'b0;
      site_queue.push_back(s);
    end
    for (int k = 0; k < 9; k++) begin
      s.lv = (k == 4) ? {LVL_MAX, LVL_MAX, LVL_MAX} : {LVL_MIN, LVL_MIN, LVL_MIN};
      s.border = 1'b0;
      site_queue.push_back(s);
    end
    // border sites take the outside levels
    for (int k = 0; k < 9; k++) begin
      for (int ch = 0; ch < NUM_CH; ch++) s.lv[ch] = $urandom();
      s.border = (k != 4);
      site_queue.push_back(s);
    end
    drain();

    // widest grid: column register above range clamps to the store depth;
    // the receiver holds off once in the middle of this round
    write_levels(pick_gain(), pick_gain(), pick_gain(), pick_level(), pick_level(),
                 pick_level());
    run_round(127, 0, 1, 1'b0);

    random_sites = 0;
    while (random_sites < RANDOM_SITES) begin
      idle_on = (random_sites < CALM_FROM);
      write_levels(pick_gain(), pick_gain(), pick_gain(), pick_level(), pick_level(),
                   pick_level());
      case ($urandom_range(0, 9))
        0: begin
          cols_w = $urandom_range(9, 127);
          rows_w = 3;
        end
        1: begin
          cols_w = $urandom_range(0, 2);
          rows_w = $urandom_range(0, 5);
        end
        default: begin
          cols_w = $urandom_range(3, 8);
          rows_w = $urandom_range(3, 7);
        end
      endcase
      run_round(cols_w, rows_w, $urandom_range(0, 2), $urandom_range(0, 3) == 0);
      random_sites += grid_extent(int'(cols_sh), MAX_COLS) *
                      grid_extent(int'(rows_sh), MAX_ROWS);
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && due_levels.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
hdl/npds_pkg.sv
hdl/npds_ram.sv
hdl/npds_raster.sv
hdl/npds_chan.sv
hdl/nine_point_diffusion_stencil_top.sv
sim/tb.sv
